// ===== design/base64_stream_decoder_unit_macros.svh =====
// assertion macros for the base64 stream decoder
`ifndef BASE64_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE64_STREAM_DECODER_UNIT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define B64D_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("b64d invariant violated");

// when pre holds, post must hold in the next cycle
`define B64D_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("b64d sequence violated");

`endif

// ===== design/b64d_pkg.sv =====
// types, constants and the alphabet lookup shared by the base64 decoder
package b64d_pkg;

  localparam int COUNT_BITS     = 16;
  localparam int QUEUE_DEPTH    = 4;   // power of two, pointers wrap naturally
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]  PAD_CHAR     = 8'd61;   // '='
  localparam logic [7:0]  CHAR_UPPER_A = 8'd65;   // 'A'
  localparam logic [7:0]  CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0]  CHAR_LOWER_A = 8'd97;
  localparam logic [7:0]  CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0]  CHAR_DIGIT_0 = 8'd48;
  localparam logic [7:0]  CHAR_DIGIT_9 = 8'd57;
  localparam logic [7:0]  CHAR_PLUS    = 8'd43;
  localparam logic [7:0]  CHAR_SLASH   = 8'd47;
  localparam logic [5:0]  SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0]  SEXTET_DIGIT_BASE = 6'd52;
  localparam logic [5:0]  SEXTET_PLUS  = 6'd62;
  localparam logic [5:0]  SEXTET_SLASH = 6'd63;
  localparam logic [15:0] TOTAL_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } char_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        message_end;
    logic [15:0] total_bytes;
  } result_item_t;

  // work handed from the front to the back: one to three results
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      num_results;  // 1..3
    logic            has_bytes;    // 0 only for a message end that adds no byte
    logic            last;
    logic [15:0]     total;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t map_sextet(input logic [7:0] c);
    sextet_t s;
    s.ok    = 1'b1;
    s.value = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      s.value = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      s.value = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      s.value = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
    end else if (c == CHAR_PLUS) begin
      s.value = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      s.value = SEXTET_SLASH;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== design/base64_stream_decoder_unit.sv =====
// top level of the base64 stream decoder
// Takes one character per cycle on the char channel and returns decoded bytes on the
// res channel, one result per cycle while res_stall is low. A character is classified
// and folded into the current group in the cycle it is accepted; a fourth sextet or a
// message end turns into a job of one to three results in a four-entry queue, which
// the back end drains at that rate through its output register. Valid text (four
// characters for three bytes) therefore runs at one character per cycle; once four
// jobs wait in the queue the char channel stalls until the res side catches up.
// A message end with no byte yields a single result with byte_valid low.
`include "base64_stream_decoder_unit_macros.svh"

module base64_stream_decoder_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    char_valid,
  output logic                    char_stall,
  input  b64d_pkg::char_item_t    char_data,
  output logic                    res_valid,
  input  logic                    res_stall,
  output b64d_pkg::result_item_t  res_data
);

  logic                     push;
  logic                     pop;
  b64d_pkg::job_t           push_job;
  b64d_pkg::job_t           head;
  b64d_pkg::queue_status_t  q_status;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .q_status   (q_status),
    .push       (push),
    .push_job   (push_job)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  // a result without a byte only ever closes a message
  `B64D_ASSERT_ALWAYS(a_nobyte_is_end, !res_valid || res_data.byte_valid || (res_data.message_end && res_data.data_byte == 8'd0))
  // the count travels only on the final result
  `B64D_ASSERT_ALWAYS(a_total_only_at_end, !res_valid || res_data.message_end || res_data.total_bytes == 16'd0)
  // queue cannot be both empty and full
  `B64D_ASSERT_ALWAYS(a_queue_status, !(q_status.empty && q_status.full))
  // retiring a job always leaves a result in the output register
  `B64D_ASSERT_NEXT(a_pop_gives_result, pop, res_valid)

endmodule

// ===== design/b64d_front.sv =====
// front end: classifies characters, gathers sextets and builds result jobs
module b64d_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     char_valid,
  output logic                     char_stall,
  input  b64d_pkg::char_item_t     char_data,
  input  b64d_pkg::queue_status_t  q_status,
  output logic                     push,
  output b64d_pkg::job_t           push_job
);

  logic [2:0][5:0]                   sextet_buffer;
  logic [1:0]                        sextet_count;
  logic                              padding_seen;
  logic [b64d_pkg::COUNT_BITS-1:0]   byte_counter;

  logic                              accept;
  b64d_pkg::sextet_t                 sx;
  logic                              store;
  logic                              group_done;
  logic [2:0][5:0]                   buf_upd;
  logic [1:0]                        count_upd;
  logic                              pad_upd;
  logic [1:0]                        n_add;
  logic [b64d_pkg::COUNT_BITS:0]     sum;
  logic [b64d_pkg::COUNT_BITS-1:0]   counter_sat;
  logic [31:0]                       counter_wide;

  assign char_stall = q_status.full;
  assign accept     = char_valid && !char_stall;
  assign sx         = b64d_pkg::map_sextet(char_data.char_code);

  always_comb begin
    store      = 1'b0;
    group_done = 1'b0;
    pad_upd    = padding_seen;
    if (!padding_seen) begin
      if (char_data.char_code == b64d_pkg::PAD_CHAR) begin
        pad_upd = 1'b1;
      end else if (sx.ok) begin
        if (sextet_count < 2'd3) begin
          store = 1'b1;
        end else begin
          group_done = 1'b1;
        end
      end
    end

    buf_upd   = sextet_buffer;
    count_upd = sextet_count;
    if (store) begin
      buf_upd[sextet_count] = sx.value;
      count_upd = sextet_count + 2'd1;
    end else if (group_done) begin
      count_upd = 2'd0;
    end

    // leftover bytes use the updated buffer, group bytes take the new sextet last
    push_job.bytes[0] = {buf_upd[0], buf_upd[1][5:4]};
    push_job.bytes[1] = {buf_upd[1][3:0], buf_upd[2][5:2]};
    push_job.bytes[2] = {buf_upd[2][1:0], sx.value};
    push_job.last     = char_data.end_of_input;

    n_add = 2'd0;
    if (group_done) begin
      n_add = 2'd3;
    end else if (char_data.end_of_input && count_upd == 2'd2) begin
      n_add = 2'd1;
    end else if (char_data.end_of_input && count_upd == 2'd3) begin
      n_add = 2'd2;
    end

    push_job.has_bytes   = (n_add != 2'd0);
    push_job.num_results = push_job.has_bytes ? n_add : 2'd1;

    sum = {1'b0, byte_counter} + (b64d_pkg::COUNT_BITS + 1)'(n_add);
    counter_sat  = sum[b64d_pkg::COUNT_BITS] ? '1 : sum[b64d_pkg::COUNT_BITS-1:0];
    counter_wide = 32'(counter_sat);
    push_job.total = (counter_wide > 32'(b64d_pkg::TOTAL_MAX)) ?
                     b64d_pkg::TOTAL_MAX : counter_wide[15:0];
  end

  assign push = accept && (push_job.has_bytes || char_data.end_of_input);

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_buffer <= '0;
      sextet_count  <= '0;
      padding_seen  <= 1'b0;
      byte_counter  <= '0;
    end else if (accept) begin
      if (char_data.end_of_input) begin
        sextet_buffer <= '0;
        sextet_count  <= '0;
        padding_seen  <= 1'b0;
        byte_counter  <= '0;
      end else begin
        sextet_buffer <= buf_upd;
        sextet_count  <= count_upd;
        padding_seen  <= pad_upd;
        byte_counter  <= counter_sat;
      end
    end
  end

endmodule

// ===== design/b64d_queue.sv =====
// small register queue of jobs between front and back
module b64d_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  b64d_pkg::job_t           push_job,
  input  logic                     pop,
  output b64d_pkg::job_t           head,
  output b64d_pkg::queue_status_t  q_status
);

  b64d_pkg::job_t                     entries [b64d_pkg::QUEUE_DEPTH];
  logic [b64d_pkg::QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [b64d_pkg::QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [b64d_pkg::QUEUE_PTR_BITS:0]   count;

  assign head           = entries[rd_ptr];
  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == (b64d_pkg::QUEUE_PTR_BITS + 1)'(b64d_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + b64d_pkg::QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + b64d_pkg::QUEUE_PTR_BITS'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (b64d_pkg::QUEUE_PTR_BITS + 1)'(1);
        2'b01:   count <= count - (b64d_pkg::QUEUE_PTR_BITS + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/b64d_back.sv =====
// back end: splits each job into result transactions behind an output register
module b64d_back (
  input  logic                     clk,
  input  logic                     rst,
  input  b64d_pkg::job_t           head,
  input  b64d_pkg::queue_status_t  q_status,
  output logic                     pop,
  output logic                     res_valid,
  input  logic                     res_stall,
  output b64d_pkg::result_item_t   res_data
);

  logic [1:0] idx;
  logic       advance;
  logic       final_of_job;

  assign advance      = !res_valid || !res_stall;
  assign final_of_job = (idx == head.num_results - 2'd1);
  assign pop          = advance && !q_status.empty && final_of_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      res_valid <= !q_status.empty;
      if (!q_status.empty) begin
        idx <= final_of_job ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !q_status.empty) begin
      res_data.data_byte   <= head.has_bytes ? head.bytes[idx] : 8'd0;
      res_data.byte_valid  <= head.has_bytes;
      res_data.message_end <= head.last && final_of_job;
      res_data.total_bytes <= (head.last && final_of_job) ? head.total : 16'd0;
    end
  end

endmodule
